/* rtl/core/pse_pkg.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 128;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SYM_W = 8;
    localparam int unsigned STATUS_W = 3;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SYMBOL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;
    localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd5;

    typedef enum logic [2:0] {
        OP_DIGIT = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_BAD   = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic       last;
    } t_cmd;

endpackage

/* rtl/core/pse_front.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts symbols, classifies them and pushes commands into a small queue.
// ----------------------------------------------------------------------------
module pse_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [pse_pkg::SYM_W-1:0]  i_symbol,
    input  logic                       i_last,
    output logic                       o_cmd_valid,
    input  logic                       i_cmd_take,
    output pse_pkg::t_cmd              o_cmd
);
    import pse_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push, pop;

    always_comb begin
        n_cmd.last  = i_last;
        n_cmd.digit = i_symbol[3:0];
        if (i_symbol >= SYM_ZERO && i_symbol <= SYM_NINE) begin
            n_cmd.op = OP_DIGIT;
        end else if (i_symbol == SYM_PLUS) begin
            n_cmd.op = OP_ADD;
        end else if (i_symbol == SYM_MINUS) begin
            n_cmd.op = OP_SUB;
        end else if (i_symbol == SYM_MUL) begin
            n_cmd.op = OP_MUL;
        end else if (i_symbol == SYM_DIV) begin
            n_cmd.op = OP_DIV;
        end else begin
            n_cmd.op = OP_BAD;
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> o_stall) else $error("full queue lost stall");
`endif

endmodule

/* rtl/core/pse_div.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Radix-2 restoring divider for signed 32-bit truncating division.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pse_pkg::DATA_W-1:0]   i_num,
    input  logic [pse_pkg::DATA_W-1:0]   i_den,
    output logic                         o_done,
    output logic [pse_pkg::DATA_W-1:0]   o_quot
);
    import pse_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_rem, r_quo, r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_neg;
    logic [DATA_W:0]   n_trial;
    logic [DATA_W-1:0] n_rem;

    always_comb begin
        n_rem   = {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
        n_trial = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_den};
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(DATA_W));
    assign o_quot = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
            r_den <= i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy && !o_done) begin
            if (!n_trial[DATA_W]) begin
                r_rem <= n_trial[DATA_W-1:0];
            end else begin
                r_rem <= n_rem;
            end
            r_quo <= {r_quo[DATA_W-2:0], !n_trial[DATA_W]};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DATA_W)) else $error("divider count out of range");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_start) |=> !r_busy) else $error("divider did not finish");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy || o_done) else $error("divider restarted while busy");
`endif

endmodule

/* rtl/core/pse_back.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator back end
// Executes commands against the operand stack and produces results.
// ----------------------------------------------------------------------------
module pse_back #(
    parameter int unsigned STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_take,
    input  pse_pkg::t_cmd                 i_cmd,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [pse_pkg::DATA_W-1:0] o_value,
    output logic [pse_pkg::STATUS_W-1:0]  o_status
);
    import pse_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_EXEC  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    logic [DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd, r_rhs, r_lhs, r_bottom;
    logic [AW-1:0]       r_rd_addr;
    t_state              r_state;
    t_cmd                r_cmd;
    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_err;
    logic                r_ovalid;
    logic [DATA_W-1:0]   r_oval;
    logic [STATUS_W-1:0] r_ostat;
    logic [DATA_W-1:0]   r_prod;
    logic                r_wr;
    logic [AW-1:0]       r_wr_addr;
    logic [DATA_W-1:0]   r_wr_data;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_quot;
    logic [AW-1:0]     top_addr;

    assign top_addr   = AW'(r_count - CW'(1));
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid    = r_ovalid;
    assign o_value    = r_oval;
    assign o_status   = r_ostat;
    assign div_start  = (r_state == S_EXEC) && (r_cmd.op == OP_DIV)
                        && (r_rhs != '0);

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_rd),
        .i_den   (r_rhs),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_mem[r_wr_addr] <= r_wr_data;
        end
        r_rd <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_wr <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (r_err != ST_OK) begin
                            r_state <= S_FIN;
                        end else if (i_cmd.op == OP_DIGIT) begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                r_err <= ST_OVER;
                            end else begin
                                r_wr      <= 1'b1;
                                r_wr_addr <= AW'(r_count);
                                r_wr_data <= DATA_W'(i_cmd.digit);
                                if (r_count == '0) begin
                                    r_bottom <= DATA_W'(i_cmd.digit);
                                end
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_FIN;
                        end else if (i_cmd.op == OP_BAD) begin
                            r_err   <= ST_SYMBOL;
                            r_state <= S_FIN;
                        end else if (r_count < CW'(2)) begin
                            r_err   <= ST_UNDER;
                            r_state <= S_FIN;
                        end else begin
                            r_rd_addr <= top_addr;
                            r_state   <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    r_rd_addr <= AW'(r_count - CW'(2));
                    r_state   <= S_RD2;
                end
                S_RD2: begin
                    r_rhs   <= r_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_lhs   <= r_rd;
                    r_prod  <= r_rd * r_rhs;
                    r_count <= r_count - CW'(2);
                    r_state <= S_DIV;
                    if (r_cmd.op == OP_DIV && r_rhs == '0) begin
                        r_err   <= ST_DIVZERO;
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (r_cmd.op != OP_DIV || div_done) begin
                        r_wr      <= 1'b1;
                        r_wr_addr <= AW'(r_count);
                        case (r_cmd.op)
                            OP_ADD:  r_wr_data <= r_lhs + r_rhs;
                            OP_SUB:  r_wr_data <= r_lhs - r_rhs;
                            OP_MUL:  r_wr_data <= r_prod;
                            default: r_wr_data <= div_quot;
                        endcase
                        if (r_count == '0) begin
                            case (r_cmd.op)
                                OP_ADD:  r_bottom <= r_lhs + r_rhs;
                                OP_SUB:  r_bottom <= r_lhs - r_rhs;
                                OP_MUL:  r_bottom <= r_prod;
                                default: r_bottom <= div_quot;
                            endcase
                        end
                        r_count <= r_count + 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_cmd.last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        if (r_err != ST_OK) begin
                            r_oval  <= '0;
                            r_ostat <= r_err;
                        end else if (r_count != CW'(1)) begin
                            r_oval  <= '0;
                            r_ostat <= ST_COUNT;
                        end else begin
                            r_oval  <= r_bottom;
                            r_ostat <= ST_OK;
                        end
                        r_count <= '0;
                        r_err   <= ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH)) else $error("stack count out of range");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_ok_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_value == '0)
        else $error("error result carries a value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_value))
        else $error("stalled result changed");
`endif

endmodule

/* rtl/core/postfix_stack_evaluator.sv */
// Throughput: one symbol at a time in the back end; the 32-step divider sets the worst case.
// A two-entry command queue lets symbols arrive while the back end works.
// Reset is synchronous, active low; it empties the queue and the stack.
// The stack memory is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates postfix integer expressions given one ASCII symbol per transfer.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pse_pkg::SYM_W-1:0]         i_symbol,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [pse_pkg::DATA_W-1:0] o_value,
    output logic [pse_pkg::STATUS_W-1:0]      o_status
);
    import pse_pkg::*;

    logic cmd_valid, cmd_take;
    t_cmd cmd;

    pse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
